FILE: hw/rtl/mds_pkg.sv
package mds_pkg;

    // item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // scroll directions; codes 5..7 are undefined
    localparam logic [2:0] DIR_OFF   = 3'd0;
    localparam logic [2:0] DIR_LEFT  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_UP    = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;

    // config register indexes
    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_DIR  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_START,
        ST_TICK,
        ST_READ,
        ST_READ_WAIT,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // where a screen write takes its pixel from
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_SCREEN,
        SRC_IMAGE
    } src_t;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic rd_issue;
        logic rd_capture;
        logic start_set;
        logic sweep_init;
        logic sweep_step;
        logic tick_commit;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic start_copy;
        logic tick_go;
        logic sweep_last;
        logic out_busy;
    } dp_stat_t;

endpackage

FILE: hw/rtl/mds_ram.sv
module mds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/mds_ctrl.sv
module mds_ctrl
    import mds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] mode,
    output logic       in_stall,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (mode)
                        MODE_LOAD:  state_next = ST_LOAD;
                        MODE_START: state_next = ST_START;
                        MODE_TICK:  state_next = ST_TICK;
                        default:    state_next = ST_READ;
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_START:
            begin
                cmd.start_set = 1'b1;
                if (stat.start_copy)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TICK:
            begin
                if (stat.tick_go)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last pending write lands this cycle
                cmd.tick_commit = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mds_dp.sv
module mds_dp
    import mds_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    input  logic [1:0] mode,
    input  logic [5:0] pixel_address,
    input  logic [7:0] pixel_value,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       out_stall,
    output logic       out_valid,
    output logic       no_line_entered,
    output logic [7:0] screen_pixel,
    output logic [3:0] speed_scale
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int LW    = $clog2(MAXD + 1);

    // config
    logic [3:0] num_rows_reg;
    logic [3:0] num_cols_reg;
    logic [2:0] direction_reg;

    // block state
    logic          running_reg;
    logic [LW-1:0] line_index_reg;
    logic [DEPTH-1:0] valid_reg;

    // captured item
    logic [1:0] mode_cap_reg;
    logic [5:0] addr_cap_reg;
    logic [7:0] value_cap_reg;

    // sweep
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [AW-1:0] base_reg;
    logic [CW-1:0] loff_reg;
    logic [AW-1:0] lbase_reg;
    logic          asc_reg;
    logic          copy_reg;
    logic          take_reg;

    // write stage
    logic          wr_pend_reg;
    logic [AW-1:0] wr_addr_reg;
    src_t          wr_src_reg;
    logic          vq_reg;

    // result
    logic       none_reg;
    logic [7:0] pix_reg;
    logic       out_valid_reg;
    logic       out_none_reg;
    logic [7:0] out_pix_reg;
    logic [3:0] out_scale_reg;

    logic [4:0]    rows_c;
    logic [4:0]    cols_c;
    logic [RW-1:0] rows_m1;
    logic [CW-1:0] cols_m1;
    logic          horiz;
    logic          vert;
    logic          addr_ok;
    logic [AW-1:0] cap_addr;
    logic          copy_w;
    logic          asc_w;
    logic          take_w;
    logic [RW-1:0] lsel_w;
    logic [CW-1:0] loff_w;
    logic [RW+4:0] base_top_w;
    logic [RW+4:0] lbase_w;
    logic [AW-1:0] pos;
    logic          edge_w;
    logic [AW-1:0] img_raddr;
    logic [AW-1:0] scr_src;
    logic [AW-1:0] scr_raddr;
    src_t          src_w;
    logic          last_w;
    logic [7:0]    scr_q;
    logic [7:0]    img_q;
    logic [7:0]    scr_wdata;
    logic [3:0]    scale_w;

    // dimensions: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        if (num_rows_reg == 4'd0)
            rows_c = 5'd1;
        else if ({1'b0, num_rows_reg} > 5'(MAX_ROWS))
            rows_c = 5'(MAX_ROWS);
        else
            rows_c = {1'b0, num_rows_reg};
        if (num_cols_reg == 4'd0)
            cols_c = 5'd1;
        else if ({1'b0, num_cols_reg} > 5'(MAX_COLS))
            cols_c = 5'(MAX_COLS);
        else
            cols_c = {1'b0, num_cols_reg};
    end

    assign rows_m1 = RW'(rows_c - 5'd1);
    assign cols_m1 = CW'(cols_c - 5'd1);
    assign horiz   = (direction_reg == DIR_LEFT) || (direction_reg == DIR_RIGHT);
    assign vert    = (direction_reg == DIR_UP) || (direction_reg == DIR_DOWN);
    assign addr_ok = ({3'b000, addr_cap_reg} < 9'(DEPTH));
    assign cap_addr = AW'(addr_cap_reg);

    // sweep setup
    assign copy_w = (mode_cap_reg == MODE_START);
    assign asc_w  = copy_w || (direction_reg == DIR_LEFT) || (direction_reg == DIR_UP);
    assign take_w = horiz ? (32'(line_index_reg) < 32'(cols_c))
                          : (32'(line_index_reg) < 32'(rows_c));
    assign loff_w = (direction_reg == DIR_LEFT) ? CW'(line_index_reg)
                  : CW'(32'(cols_m1) - 32'(line_index_reg));
    assign lsel_w = (direction_reg == DIR_UP) ? RW'(line_index_reg)
                  : RW'(32'(rows_m1) - 32'(line_index_reg));
    assign base_top_w = {5'b00000, rows_m1} * {{RW{1'b0}}, cols_c};
    assign lbase_w    = {5'b00000, lsel_w} * {{RW{1'b0}}, cols_c};

    // per-pixel source selection
    assign pos = base_reg + AW'(col_reg);

    always_comb
    begin
        edge_w  = 1'b0;
        scr_src = pos;
        case (direction_reg)
            DIR_LEFT:
            begin
                edge_w  = (col_reg == cols_m1);
                scr_src = pos + AW'(1);
            end
            DIR_RIGHT:
            begin
                edge_w  = (col_reg == '0);
                scr_src = pos - AW'(1);
            end
            DIR_UP:
            begin
                edge_w  = (row_reg == rows_m1);
                scr_src = AW'(32'(pos) + 32'(cols_c));
            end
            DIR_DOWN:
            begin
                edge_w  = (row_reg == '0);
                scr_src = AW'(32'(pos) - 32'(cols_c));
            end
            default:
            begin
                edge_w  = 1'b0;
                scr_src = pos;
            end
        endcase

        if (copy_reg)
            src_w = SRC_IMAGE;
        else if (edge_w)
            src_w = take_reg ? SRC_IMAGE : SRC_ZERO;
        else
            src_w = SRC_SCREEN;

        if (copy_reg)
            img_raddr = pos;
        else if (horiz)
            img_raddr = base_reg + AW'(loff_reg);
        else
            img_raddr = lbase_reg + AW'(col_reg);
    end

    assign scr_raddr = cmd.rd_issue ? cap_addr : scr_src;
    assign last_w = asc_reg ? ((row_reg == rows_m1) && (col_reg == cols_m1))
                            : ((row_reg == '0) && (col_reg == '0));

    always_comb
    begin
        case (wr_src_reg)
            SRC_IMAGE:  scr_wdata = img_q;
            SRC_SCREEN: scr_wdata = vq_reg ? scr_q : 8'd0;
            default:    scr_wdata = 8'd0;
        endcase
    end

    always_comb
    begin
        case (direction_reg) inside
            DIR_OFF:             scale_w = 4'd1;
            DIR_LEFT, DIR_RIGHT: scale_w = 4'(cols_c + 5'd1);
            DIR_UP, DIR_DOWN:    scale_w = 4'(rows_c + 5'd1);
            default:             scale_w = 4'd0;
        endcase
    end

    mds_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_screen (
        .clk   (clk),
        .we    (wr_pend_reg),
        .waddr (wr_addr_reg),
        .wdata (scr_wdata),
        .raddr (scr_raddr),
        .rdata (scr_q)
    );

    mds_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_image (
        .clk   (clk),
        .we    (cmd.load_wr && addr_ok),
        .waddr (cap_addr),
        .wdata (value_cap_reg),
        .raddr (img_raddr),
        .rdata (img_q)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= 4'd8;
            num_cols_reg   <= 4'd8;
            direction_reg  <= DIR_OFF;
            running_reg    <= 1'b0;
            line_index_reg <= '0;
            valid_reg      <= '0;
            wr_pend_reg    <= 1'b0;
            vq_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ROWS: num_rows_reg  <= cfg_data;
                    CFG_COLS: num_cols_reg  <= cfg_data;
                    CFG_DIR:  direction_reg <= cfg_data[2:0];
                    default:  ;
                endcase
            end
            if (cmd.start_set)
            begin
                running_reg    <= 1'b1;
                line_index_reg <= '0;
            end
            if (cmd.tick_commit && (mode_cap_reg == MODE_TICK) && take_reg)
            begin
                line_index_reg <= LW'(line_index_reg + 1'b1);
            end
            if (wr_pend_reg)
            begin
                valid_reg[wr_addr_reg] <= 1'b1;
            end
            wr_pend_reg <= cmd.sweep_step;
            vq_reg      <= valid_reg[scr_raddr];
            if (cmd.result_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_cap_reg  <= mode;
            addr_cap_reg  <= pixel_address;
            value_cap_reg <= pixel_value;
            none_reg      <= 1'b1;
            pix_reg       <= 8'd0;
        end
        if (cmd.rd_capture)
        begin
            pix_reg <= (addr_ok && vq_reg) ? scr_q : 8'd0;
        end
        if (cmd.tick_commit && (mode_cap_reg == MODE_TICK) && take_reg)
        begin
            none_reg <= 1'b0;
        end
        if (cmd.sweep_init)
        begin
            copy_reg  <= copy_w;
            asc_reg   <= asc_w;
            take_reg  <= take_w;
            loff_reg  <= loff_w;
            lbase_reg <= AW'(lbase_w);
            row_reg   <= asc_w ? '0 : rows_m1;
            col_reg   <= asc_w ? '0 : cols_m1;
            base_reg  <= asc_w ? '0 : AW'(base_top_w);
        end
        else if (cmd.sweep_step)
        begin
            if (asc_reg)
            begin
                if (col_reg == cols_m1)
                begin
                    col_reg  <= '0;
                    row_reg  <= RW'(row_reg + 1'b1);
                    base_reg <= AW'(32'(base_reg) + 32'(cols_c));
                end
                else
                begin
                    col_reg <= CW'(col_reg + 1'b1);
                end
            end
            else
            begin
                if (col_reg == '0)
                begin
                    col_reg  <= cols_m1;
                    row_reg  <= RW'(row_reg - 1'b1);
                    base_reg <= AW'(32'(base_reg) - 32'(cols_c));
                end
                else
                begin
                    col_reg <= CW'(col_reg - 1'b1);
                end
            end
        end
        wr_addr_reg <= pos;
        wr_src_reg  <= src_w;
        if (cmd.result_load)
        begin
            out_none_reg  <= none_reg;
            out_pix_reg   <= pix_reg;
            out_scale_reg <= scale_w;
        end
    end

    assign stat.start_copy = (direction_reg == DIR_OFF);
    assign stat.tick_go    = running_reg && (horiz || vert);
    assign stat.sweep_last = last_w;
    assign stat.out_busy   = out_valid_reg && out_stall;

    assign out_valid       = out_valid_reg;
    assign no_line_entered = out_none_reg;
    assign screen_pixel    = out_pix_reg;
    assign speed_scale     = out_scale_reg;

endmodule

FILE: hw/rtl/matrix_display_scroller.sv
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------------------
// in       in_valid / in_stall    mode, pixel_address, pixel_value
// out      out_valid / out_stall  no_line_entered, screen_pixel, speed_scale
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (rows, cols, direction)
//
// One item at a time. Load, start without copy and idle ticks go on to DONE;
// a read goes via READ_WAIT; a start copy or moving tick sweeps rows*cols pixels.
// The sweep is set by the screen RAM's single write port: one pixel a cycle.
// Reset clears control state and the screen valid bits; no clearing pass.
// A finished result waits in the output register while out_stall is high;
// the next item is taken meanwhile and holds in its last state until free.
module matrix_display_scroller
    import mds_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [5:0] pixel_address,
    input  logic [7:0] pixel_value,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       no_line_entered,
    output logic [7:0] screen_pixel,
    output logic [3:0] speed_scale,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // config writes land whenever offered
    assign cfg_ready = 1'b1;

    // sequencer: one state per step of an item, sweep loops one pixel a cycle
    mds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // stores, sweep counters, config and output register
    mds_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .mode            (mode),
        .pixel_address   (pixel_address),
        .pixel_value     (pixel_value),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .no_line_entered (no_line_entered),
        .screen_pixel    (screen_pixel),
        .speed_scale     (speed_scale)
    );

endmodule

FILE: hw/rtl/mds_checker.sv
module mds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       no_line_entered,
    input logic [7:0] screen_pixel,
    input logic [3:0] speed_scale
);

    // one item in flight: an accepted item closes the input next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in flight");

    // a read never reports an entered line
    a_read_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (screen_pixel != 8'd0)) |-> no_line_entered)
        else $error("pixel result with line entered");

    // a tick that took a line carries no pixel
    a_tick_pix: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !no_line_entered) |-> (screen_pixel == 8'd0))
        else $error("tick result carries a pixel");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(screen_pixel) && $stable(no_line_entered)
             && $stable(speed_scale)))
        else $error("stalled result changed");

endmodule

bind matrix_display_scroller mds_checker u_mds_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .no_line_entered (no_line_entered),
    .screen_pixel    (screen_pixel),
    .speed_scale     (speed_scale)
);
